@@ sv/bsfr_pkg.sv @@
// Types and constants shared by the byte-stuffed frame receiver.
`default_nettype none

package bsfr_pkg;

  // Largest raw length the receiver allows, whatever max_length holds.
  localparam int MAX_FRAME = 256;

  localparam int CountW = 9;
  localparam int ByteW = 8;
  localparam int KindW = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 9;
  localparam int LimitW = 17;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_DATA = 3'd0;
  localparam logic [KindW-1:0] KIND_GOOD = 3'd1;
  localparam logic [KindW-1:0] KIND_LONG = 3'd2;
  localparam logic [KindW-1:0] KIND_SHORT = 3'd3;
  localparam logic [KindW-1:0] KIND_ABORT = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_START_BYTE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STOP_BYTE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ESCAPE_BYTE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STUFF_MASK = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] START_BYTE_RST = 8'hFC;
  localparam logic [ByteW-1:0] STOP_BYTE_RST = 8'hFD;
  localparam logic [ByteW-1:0] ESCAPE_BYTE_RST = 8'hFE;
  localparam logic [ByteW-1:0] STUFF_MASK_RST = 8'h20;
  localparam logic [CountW-1:0] MAX_LENGTH_RST = 9'd256;
  localparam logic [CountW-1:0] MIN_LENGTH_RST = 9'd4;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [KindW-1:0] out_kind;
    logic [CountW-1:0] raw_length;
    logic [CountW-1:0] data_length;
  } result_t;

endpackage

`default_nettype wire

@@ sv/byte_stuffed_frame_receiver.sv @@
// Byte-stuffed frame receiver: hunts for frames, destuffs bytes, reports frame status.
//
//   channel  direction  handshake             payload
//   rx       in         rx_valid / rx_ready   rx_byte
//   out      out        out_valid / out_ready out_byte, out_kind, raw_length, data_length
//   cfg      in         cfg_write             cfg_index, cfg_data
//
// Each byte is decoded in the cycle it is accepted; any result is registered in the
// output register, or in a second result register that catches it while output stalls;
// one byte per cycle is sustained while the output takes results. rx_ready drops only
// while both registers hold results. Reset is synchronous and returns the receiver to
// hunting with default configuration.
`default_nettype none

module byte_stuffed_frame_receiver import bsfr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                rx_valid,
  output logic                     rx_ready,
  input  wire logic [ByteW-1:0]    rx_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ByteW-1:0]         out_byte,
  output logic [KindW-1:0]         out_kind,
  output logic [CountW-1:0]        raw_length,
  output logic [CountW-1:0]        data_length
);

  localparam logic [LimitW-1:0] MaxFrameW = LimitW'(MAX_FRAME);

  logic [ByteW-1:0] start_byte;
  logic [ByteW-1:0] stop_byte;
  logic [ByteW-1:0] escape_byte;
  logic [ByteW-1:0] stuff_mask;
  logic [CountW-1:0] max_length;
  logic [CountW-1:0] min_length;

  logic in_frame, in_frame_next;
  logic escape_pending, escape_pending_next;
  logic [CountW-1:0] raw_count, raw_count_next;
  logic [CountW-1:0] data_count, data_count_next;

  logic accept;
  logic has_result;
  result_t result;
  result_t out_reg;
  result_t skid;
  logic skid_valid;
  logic pop;

  logic [LimitW-1:0] limit;
  logic [CountW-1:0] raw_inc;
  logic too_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      stop_byte <= STOP_BYTE_RST;
      escape_byte <= ESCAPE_BYTE_RST;
      stuff_mask <= STUFF_MASK_RST;
      max_length <= MAX_LENGTH_RST;
      min_length <= MIN_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data[ByteW-1:0];
        REG_STOP_BYTE: stop_byte <= cfg_data[ByteW-1:0];
        REG_ESCAPE_BYTE: escape_byte <= cfg_data[ByteW-1:0];
        REG_STUFF_MASK: stuff_mask <= cfg_data[ByteW-1:0];
        REG_MAX_LENGTH: max_length <= cfg_data;
        REG_MIN_LENGTH: min_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx_ready = !skid_valid;
  assign accept = rx_valid && rx_ready;
  assign pop = out_valid && out_ready;

  // The raw count is capped by the smaller of max_length and the frame limit.
  assign limit = ({{(LimitW-CountW){1'b0}}, max_length} > MaxFrameW) ?
                 MaxFrameW : {{(LimitW-CountW){1'b0}}, max_length};
  assign raw_inc = raw_count + 1'b1;
  assign too_long = {{(LimitW-CountW){1'b0}}, raw_inc} >= limit;

  always_comb begin
    in_frame_next = in_frame;
    escape_pending_next = escape_pending;
    raw_count_next = raw_count;
    data_count_next = data_count;
    has_result = 1'b0;
    result = '0;
    priority if (!in_frame) begin
      if (rx_byte == start_byte) begin
        in_frame_next = 1'b1;
        escape_pending_next = 1'b0;
        raw_count_next = '0;
        data_count_next = '0;
      end
    end else if (rx_byte == start_byte) begin
      // Restart inside a frame; bytes may already have gone out, so report it if any were counted.
      in_frame_next = 1'b1;
      escape_pending_next = 1'b0;
      raw_count_next = '0;
      data_count_next = '0;
      has_result = (raw_count != '0);
      result.out_kind = KIND_ABORT;
      result.raw_length = raw_count;
      result.data_length = data_count;
    end else if (too_long) begin
      in_frame_next = 1'b0;
      escape_pending_next = 1'b0;
      raw_count_next = raw_inc;
      has_result = 1'b1;
      result.out_kind = KIND_LONG;
      result.raw_length = raw_inc;
      result.data_length = data_count;
    end else if (rx_byte == stop_byte) begin
      in_frame_next = 1'b0;
      escape_pending_next = 1'b0;
      raw_count_next = raw_inc;
      has_result = 1'b1;
      result.out_kind = (raw_inc < min_length) ? KIND_SHORT : KIND_GOOD;
      result.raw_length = raw_count;
      result.data_length = data_count;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      raw_count_next = raw_inc;
      if (rx_byte != escape_byte) begin
        data_count_next = data_count + 1'b1;
        has_result = 1'b1;
        result.out_byte = rx_byte ^ stuff_mask;
        result.out_kind = KIND_DATA;
      end
    end else if (rx_byte == escape_byte) begin
      escape_pending_next = 1'b1;
      raw_count_next = raw_inc;
    end else begin
      raw_count_next = raw_inc;
      data_count_next = data_count + 1'b1;
      has_result = 1'b1;
      result.out_byte = rx_byte;
      result.out_kind = KIND_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      escape_pending <= 1'b0;
      raw_count <= '0;
      data_count <= '0;
    end else if (accept) begin
      in_frame <= in_frame_next;
      escape_pending <= escape_pending_next;
      raw_count <= raw_count_next;
      data_count <= data_count_next;
    end
  end

  // Output register with one catch register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (!out_valid || pop) begin
        out_reg <= result;
        out_valid <= 1'b1;
      end else begin
        skid <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign out_byte = out_reg.out_byte;
  assign out_kind = out_reg.out_kind;
  assign raw_length = out_reg.raw_length;
  assign data_length = out_reg.data_length;

endmodule

`default_nettype wire

@@ verif/bsfr_checker.sv @@
`timescale 1ns / 100ps
// Checker for the byte-stuffed frame receiver: tracks configuration, predicts results, compares.
module bsfr_checker import bsfr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                rx_valid,
  input  logic                rx_ready,
  input  logic [ByteW-1:0]    rx_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [ByteW-1:0]    out_byte,
  input  logic [KindW-1:0]    out_kind,
  input  logic [CountW-1:0]   raw_length,
  input  logic [CountW-1:0]   data_length,
  output int                  mismatches,
  output int                  outstanding,
  output int                  data_seen,
  output int                  good_seen,
  output int                  long_seen,
  output int                  short_seen,
  output int                  abort_seen
);

  localparam int ReportLimit = 20;

  logic [ByteW-1:0]  start_b, stop_b, esc_b, mask_b;
  logic [CountW-1:0] max_len, min_len;

  bit in_frame;
  bit esc_pending;
  int raw_cnt;
  int data_cnt;

  result_t deframed_q[$];

  function automatic result_t make_result(input logic [ByteW-1:0] b, input logic [KindW-1:0] k,
                                          input int raw, input int dat);
    result_t r;
    r.out_byte = b;
    r.out_kind = k;
    r.raw_length = raw[CountW-1:0];
    r.data_length = dat[CountW-1:0];
    return r;
  endfunction

  // Decodes one accepted byte and queues the result it causes, if any.
  task automatic deframe_byte(input logic [ByteW-1:0] b);
    int limit;
    limit = (int'(max_len) > MAX_FRAME) ? MAX_FRAME : int'(max_len);
    if (!in_frame) begin
      if (b == start_b) begin
        in_frame = 1'b1;
        esc_pending = 1'b0;
        raw_cnt = 0;
        data_cnt = 0;
      end
    end else if (b == start_b) begin
      // A restart only reports an abort when something followed the old start.
      if (raw_cnt > 0) deframed_q.push_back(make_result('0, KIND_ABORT, raw_cnt, data_cnt));
      esc_pending = 1'b0;
      raw_cnt = 0;
      data_cnt = 0;
    end else begin
      raw_cnt++;
      if (raw_cnt >= limit) begin
        deframed_q.push_back(make_result('0, KIND_LONG, raw_cnt, data_cnt));
        in_frame = 1'b0;
        esc_pending = 1'b0;
      end else if (b == stop_b) begin
        deframed_q.push_back(make_result('0, (raw_cnt < int'(min_len)) ? KIND_SHORT : KIND_GOOD,
                                         raw_cnt - 1, data_cnt));
        in_frame = 1'b0;
        esc_pending = 1'b0;
      end else if (esc_pending) begin
        esc_pending = 1'b0;
        if (b != esc_b) begin
          data_cnt++;
          deframed_q.push_back(make_result(b ^ mask_b, KIND_DATA, 0, 0));
        end
      end else if (b == esc_b) begin
        esc_pending = 1'b1;
      end else begin
        data_cnt++;
        deframed_q.push_back(make_result(b, KIND_DATA, 0, 0));
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    bit bad;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: result with none expected: byte %h kind %0d raw %0d data %0d",
                 $time, out_byte, out_kind, raw_length, data_length);
      return;
    end
    want = deframed_q.pop_front();
    bad = 1'b0;
    if (out_byte !== want.out_byte) begin
      bad = 1'b1;
      if (mismatches < ReportLimit)
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, out_byte);
    end
    if (out_kind !== want.out_kind) begin
      bad = 1'b1;
      if (mismatches < ReportLimit)
        $display("%0t: out_kind expected %0d actual %0d", $time, want.out_kind, out_kind);
    end
    if (raw_length !== want.raw_length) begin
      bad = 1'b1;
      if (mismatches < ReportLimit)
        $display("%0t: raw_length expected %0d actual %0d", $time, want.raw_length, raw_length);
    end
    if (data_length !== want.data_length) begin
      bad = 1'b1;
      if (mismatches < ReportLimit)
        $display("%0t: data_length expected %0d actual %0d", $time, want.data_length,
                 data_length);
    end
    if (bad) mismatches++;
    if (want.out_kind == KIND_DATA) data_seen++;
    else if (want.out_kind == KIND_GOOD) good_seen++;
    else if (want.out_kind == KIND_LONG) long_seen++;
    else if (want.out_kind == KIND_SHORT) short_seen++;
    else abort_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_b = START_BYTE_RST;
      stop_b = STOP_BYTE_RST;
      esc_b = ESCAPE_BYTE_RST;
      mask_b = STUFF_MASK_RST;
      max_len = MAX_LENGTH_RST;
      min_len = MIN_LENGTH_RST;
      in_frame = 1'b0;
      esc_pending = 1'b0;
      raw_cnt = 0;
      data_cnt = 0;
      deframed_q.delete();
      mismatches = 0;
      outstanding = 0;
      data_seen = 0;
      good_seen = 0;
      long_seen = 0;
      short_seen = 0;
      abort_seen = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_write) begin
        case (cfg_index)
          REG_START_BYTE: start_b = cfg_data[ByteW-1:0];
          REG_STOP_BYTE: stop_b = cfg_data[ByteW-1:0];
          REG_ESCAPE_BYTE: esc_b = cfg_data[ByteW-1:0];
          REG_STUFF_MASK: mask_b = cfg_data[ByteW-1:0];
          REG_MAX_LENGTH: max_len = cfg_data;
          REG_MIN_LENGTH: min_len = cfg_data;
          default: ;
        endcase
      end
      if (rx_valid && rx_ready) deframe_byte(rx_byte);
      outstanding = deframed_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the byte-stuffed frame receiver: clock, reset, stimulus and verdict.
module tb;
  import bsfr_pkg::*;

  localparam int QuietLimit = 1000;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                rx_valid;
  logic                rx_ready;
  logic [ByteW-1:0]    rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [ByteW-1:0]    out_byte;
  logic [KindW-1:0]    out_kind;
  logic [CountW-1:0]   raw_length;
  logic [CountW-1:0]   data_length;

  int mismatches, outstanding;
  int data_seen, good_seen, long_seen, short_seen, abort_seen;

  int bytes_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  logic [ByteW-1:0] cur_start, cur_stop, cur_esc, cur_mask;
  logic [ByteW-1:0] directed_seq [24];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  byte_stuffed_frame_receiver DUT (.*);

  bsfr_checker checker_i (.*);

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 9);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
      stall_left <= idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
      $display("byte_stuffed_frame_receiver verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_rx(input logic [ByteW-1:0] b);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // Bytes that cause no result may still be in the pipeline.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] special_byte();
    case ($urandom_range(0, 2))
      0: return cur_start;
      1: return cur_stop;
      default: return cur_esc;
    endcase
  endfunction

  function automatic bit is_special(input logic [ByteW-1:0] b);
    return b == cur_start || b == cur_stop || b == cur_esc;
  endfunction

  function automatic int frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 96) return $urandom_range(9, 40);
    return $urandom_range(41, 80);
  endfunction

  // A clean frame holds only plain bytes and always ends with a stop byte. Otherwise the
  // payload is stuffed, with double escapes, restarts, an escape before the stop and a
  // missing stop mixed in.
  task automatic drive_frame(input int len, input bit clean);
    logic [ByteW-1:0] b;
    int r;
    push_rx(cur_start);
    for (int i = 0; i < len; i++) begin
      if (clean) begin
        b = ByteW'($urandom_range(0, 255));
        while (is_special(b)) b = ByteW'($urandom_range(0, 255));
        push_rx(b);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          push_rx(cur_esc);
          push_rx(cur_esc);
        end else if (r < 5) begin
          push_rx(cur_start);
        end
        if (r < 15) b = special_byte();
        else b = ByteW'($urandom_range(0, 255));
        if (is_special(b) && $urandom_range(0, 99) < 85) begin
          push_rx(cur_esc);
          push_rx(b ^ cur_mask);
        end else begin
          push_rx(b);
        end
      end
    end
    if (!clean && $urandom_range(0, 99) < 8) push_rx(cur_esc);
    if (clean || $urandom_range(0, 99) >= 6) push_rx(cur_stop);
  endtask

  task automatic run_phase(input logic [ByteW-1:0] s_b, p_b, e_b, m_b,
                           input logic [CountW-1:0] max_l, min_l,
                           input bit with_long, input int budget);
    int mark, limit, mode;
    drain_results();
    write_reg(REG_START_BYTE, {1'b0, s_b});
    write_reg(REG_STOP_BYTE, {1'b0, p_b});
    write_reg(REG_ESCAPE_BYTE, {1'b0, e_b});
    write_reg(REG_STUFF_MASK, {1'b0, m_b});
    write_reg(REG_MAX_LENGTH, max_l);
    write_reg(REG_MIN_LENGTH, min_l);
    cfg_write <= 1'b0;
    cur_start = s_b;
    cur_stop = p_b;
    cur_esc = e_b;
    cur_mask = m_b;
    tx_idle_on = 1'b1;
    out_idle_on = 1'b1;
    limit = (int'(max_l) > MAX_FRAME) ? MAX_FRAME : int'(max_l);
    if (with_long) drive_frame(limit + 3, 1'b1);
    mark = bytes_sent;
    while (bytes_sent - mark < budget) begin
      mode = $urandom_range(0, 3);
      tx_idle_on = (mode == 0 || mode == 1);
      out_idle_on = (mode == 0 || mode == 2);
      if ($urandom_range(0, 99) < 4) drain_results();
      if ($urandom_range(0, 99) < 10)
        repeat ($urandom_range(1, 4)) push_rx(ByteW'($urandom_range(0, 255)));
      drive_frame(frame_len(), 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_valid = 1'b0;
    rx_byte = '0;
    out_ready = 1'b0;
    cur_start = START_BYTE_RST;
    cur_stop = STOP_BYTE_RST;
    cur_esc = ESCAPE_BYTE_RST;
    cur_mask = STUFF_MASK_RST;
    // Noise while hunting; a frame with an escaped byte and a double escape; a restart with
    // nothing counted, then one that aborts; a pending escape at stop; a frame at min length.
    directed_seq = '{8'h00, 8'hFD,
                     8'hFC, 8'h00, 8'hFF, 8'hFE, 8'h5D, 8'hFE, 8'hFE, 8'h41, 8'hFD,
                     8'hFC, 8'hFC, 8'h11, 8'hFC, 8'hFD,
                     8'hFC, 8'hFE, 8'hFD,
                     8'hFC, 8'h01, 8'h02, 8'h03, 8'hFD};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    out_idle_on = 1'b1;
    foreach (directed_seq[i]) push_rx(directed_seq[i]);

    run_phase(START_BYTE_RST, STOP_BYTE_RST, ESCAPE_BYTE_RST, STUFF_MASK_RST,
              MAX_LENGTH_RST, MIN_LENGTH_RST, 1'b0, 200);
    run_phase(8'h01, 8'hFF, 8'h00, 8'hFF, 9'd16, 9'd0, 1'b1, 40);
    // A limit above the frame ceiling is capped, and every frame ended by a stop byte is too short.
    run_phase(8'h7E, 8'h7F, 8'h7D, 8'h20, 9'd511, 9'd256, 1'b1, 20);
    // A zero limit ends every frame on its first byte.
    run_phase(8'h00, 8'h10, 8'h01, 8'h55, 9'd0, 9'd1, 1'b1, 15);
    run_phase(8'hFF, 8'h00, 8'h02, 8'h00, 9'd1, 9'd256, 1'b1, 15);
    run_phase(8'h55, 8'hAA, 8'hFF, 8'h80, 9'd64, 9'd2, 1'b1, 60);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes over six register settings with stuffed and overlong frames.",
             bytes_sent);
    $display("Checked %0d data bytes; frames: %0d good, %0d long, %0d short, %0d aborted.",
             data_seen, good_seen, long_seen, short_seen, abort_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("byte_stuffed_frame_receiver verification clean");
    end else begin
      $display("byte_stuffed_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
